/* hdl/dfa_table_recognizer_top_defines.svh */
// Assertion macros used by the recognizer execution unit
`ifndef DFA_TABLE_RECOGNIZER_TOP_DEFINES_SVH
`define DFA_TABLE_RECOGNIZER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is low
`define DFA_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define DFA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/dfa_pkg.sv */
// Types and constants shared by the recognizer modules
`timescale 1ns / 1ps
package dfa_pkg;

    typedef enum logic [2:0] {
        ACT_CLEAR = 3'd0,
        ACT_MARK  = 3'd1,
        ACT_LOAD  = 3'd2,
        ACT_FEED  = 3'd3,
        ACT_END   = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        ST_WIPE,
        ST_RUN,
        ST_READ
    } t_back_state;

    typedef struct packed {
        t_action    action;
        logic       ok;
        logic [5:0] sidx;
        logic [7:0] sym;
        logic       tgt_def;
        logic [5:0] tgt;
    } t_cmd;

    typedef struct packed {
        logic [5:0] stop_state;
        logic       blocked;
        logic       accepted;
        logic       ok;
    } t_result;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 16;
    localparam int CNT_W      = 7;
    localparam logic [6:0] TGT_NONE = 7'h7F;

endpackage

/* hdl/dfa_front.sv */
// Input front end: config register, item decode and range checks
`timescale 1ns / 1ps
module dfa_front
    import dfa_pkg::*;
#(
    parameter int MAX_STATES    = 64,
    parameter int ALPHABET_SIZE = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    input  logic                  i_cfg_wr_en,
    input  logic [CNT_W-1:0]      i_cfg_wr_data,
    input  logic                  i_busy,
    input  logic                  i_full,
    output logic                  o_push,
    output t_cmd                  o_cmd,
    output logic [CNT_W-1:0]      o_live
);

    logic [CNT_W-1:0] r_state_count;
    logic [2:0]       act;
    logic [5:0]       sidx;
    logic [7:0]       sym;
    logic [6:0]       tgt;
    logic             accept;
    logic             too_many;
    logic             sidx_ok;
    logic             sym_ok;
    logic             tgt_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state_count <= '0;
        end else if (i_cfg_wr_en) begin
            r_state_count <= i_cfg_wr_data;
        end
    end

    assign act  = i_s_tdata[2:0];
    assign sidx = i_s_tdata[8:3];
    assign sym  = i_s_tdata[16:9];
    assign tgt  = i_s_tdata[23:17];

    assign too_many = {2'b00, r_state_count} > 9'(MAX_STATES);
    assign o_live   = too_many ? CNT_W'(MAX_STATES) : r_state_count;

    assign sidx_ok = {1'b0, sidx} < o_live;
    assign sym_ok  = {1'b0, sym} < 9'(ALPHABET_SIZE);
    assign tgt_ok  = (tgt == TGT_NONE) || (!tgt[6] && ({1'b0, tgt[5:0]} < o_live));

    assign o_s_tready = !i_busy && !i_full;
    assign accept     = i_s_tvalid && o_s_tready;

    always_comb begin
        o_push          = 1'b0;
        o_cmd.action    = ACT_CLEAR;
        o_cmd.ok        = 1'b0;
        o_cmd.sidx      = sidx;
        o_cmd.sym       = sym;
        o_cmd.tgt_def   = !tgt[6];
        o_cmd.tgt       = tgt[5:0];
        case (act)
            ACT_CLEAR: begin
                o_push       = accept;
                o_cmd.action = ACT_CLEAR;
                o_cmd.ok     = !too_many;
            end
            ACT_MARK: begin
                o_push       = accept;
                o_cmd.action = ACT_MARK;
                o_cmd.ok     = sidx_ok;
            end
            ACT_LOAD: begin
                o_push       = accept;
                o_cmd.action = ACT_LOAD;
                o_cmd.ok     = sidx_ok && sym_ok && tgt_ok;
            end
            ACT_FEED: begin
                o_push       = accept;
                o_cmd.action = ACT_FEED;
                o_cmd.ok     = sym_ok;
            end
            ACT_END: begin
                o_push       = accept;
                o_cmd.action = ACT_END;
                o_cmd.ok     = 1'b1;
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
    end

endmodule

/* hdl/dfa_queue.sv */
// Two-entry command queue between front end and execution unit
`timescale 1ns / 1ps
module dfa_queue
    import dfa_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_head
);

    t_cmd       r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       do_push;
    logic       do_pop;

    assign o_full  = r_count == 2'd2;
    assign o_empty = r_count == 2'd0;
    assign o_head  = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* hdl/dfa_back.sv */
// Execution unit: transition memory, accepting marks, walk state and result register
`timescale 1ns / 1ps
`include "dfa_table_recognizer_top_defines.svh"
module dfa_back
    import dfa_pkg::*;
#(
    parameter int MAX_STATES    = 64,
    parameter int ALPHABET_SIZE = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_empty,
    input  t_cmd                  i_head,
    output logic                  o_pop,
    input  logic [CNT_W-1:0]      i_live,
    output logic                  o_busy,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata
);

    localparam int SW    = $clog2(MAX_STATES);
    localparam int AW    = $clog2(ALPHABET_SIZE);
    localparam int ADDRW = SW + AW;
    localparam int DEPTH = MAX_STATES * (1 << AW);
    localparam int EW    = SW + 1;

    t_back_state           r_state, n_state;
    logic [ADDRW-1:0]      r_wipe_addr, n_wipe_addr;
    logic [SW-1:0]         r_cur, n_cur;
    logic                  r_blk, n_blk;
    logic [MAX_STATES-1:0] r_marks, n_marks;
    logic                  r_out_valid, n_out_valid;
    t_result               r_out_data, n_out_data;
    logic [EW-1:0]         r_mem [DEPTH];
    logic [EW-1:0]         r_rd_data;

    logic                  mem_we;
    logic [ADDRW-1:0]      mem_wa;
    logic [EW-1:0]         mem_wd;
    logic                  mem_re;
    logic [ADDRW-1:0]      mem_ra;
    logic                  slot_free;
    logic                  cur_live;
    logic                  end_blk;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_WIPE;
            r_wipe_addr <= '0;
            r_cur       <= '0;
            r_blk       <= 1'b0;
            r_marks     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wipe_addr <= n_wipe_addr;
            r_cur       <= n_cur;
            r_blk       <= n_blk;
            r_marks     <= n_marks;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    assign slot_free = !r_out_valid || i_m_tready;
    assign cur_live  = {{(9 - SW){1'b0}}, r_cur} < {2'b00, i_live};
    assign end_blk   = r_blk || !cur_live;
    assign mem_ra    = {r_cur, AW'(i_head.sym)};

    always_comb begin
        n_state     = r_state;
        n_wipe_addr = r_wipe_addr;
        n_cur       = r_cur;
        n_blk       = r_blk;
        n_marks     = r_marks;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_data  = r_out_data;
        o_pop       = 1'b0;
        mem_we      = 1'b0;
        mem_wa      = r_wipe_addr;
        mem_wd      = '0;
        mem_re      = 1'b0;
        case (r_state)
            ST_WIPE: begin
                mem_we = 1'b1;
                if (r_wipe_addr == ADDRW'(DEPTH - 1)) begin
                    n_state = ST_RUN;
                end else begin
                    n_wipe_addr = r_wipe_addr + 1'b1;
                end
            end
            ST_RUN: begin
                if (!i_empty) begin
                    case (i_head.action)
                        ACT_FEED: begin
                            o_pop = 1'b1;
                            if (!r_blk) begin
                                if (!i_head.ok || !cur_live) begin
                                    n_blk = 1'b1;
                                end else begin
                                    mem_re  = 1'b1;
                                    n_state = ST_READ;
                                end
                            end
                        end
                        ACT_END: begin
                            if (slot_free) begin
                                o_pop                 = 1'b1;
                                n_out_valid           = 1'b1;
                                n_out_data.ok         = 1'b1;
                                n_out_data.blocked    = end_blk;
                                n_out_data.accepted   = !end_blk && r_marks[r_cur];
                                n_out_data.stop_state = end_blk ? 6'd0 : 6'(r_cur);
                                n_cur                 = '0;
                                n_blk                 = 1'b0;
                            end
                        end
                        ACT_CLEAR: begin
                            if (slot_free) begin
                                o_pop       = 1'b1;
                                n_out_valid = 1'b1;
                                n_out_data  = '{stop_state: 6'd0, blocked: 1'b0,
                                                accepted: 1'b0, ok: i_head.ok};
                                if (i_head.ok) begin
                                    n_marks     = '0;
                                    n_cur       = '0;
                                    n_blk       = 1'b0;
                                    n_wipe_addr = '0;
                                    n_state     = ST_WIPE;
                                end
                            end
                        end
                        ACT_MARK: begin
                            if (slot_free) begin
                                o_pop       = 1'b1;
                                n_out_valid = 1'b1;
                                n_out_data  = '{stop_state: 6'd0, blocked: 1'b0,
                                                accepted: 1'b0, ok: i_head.ok};
                                if (i_head.ok) begin
                                    n_marks[SW'(i_head.sidx)] = 1'b1;
                                end
                            end
                        end
                        ACT_LOAD: begin
                            if (slot_free) begin
                                o_pop       = 1'b1;
                                n_out_valid = 1'b1;
                                n_out_data  = '{stop_state: 6'd0, blocked: 1'b0,
                                                accepted: 1'b0, ok: i_head.ok};
                                if (i_head.ok) begin
                                    mem_we = 1'b1;
                                    mem_wa = {SW'(i_head.sidx), AW'(i_head.sym)};
                                    mem_wd = {i_head.tgt_def, SW'(i_head.tgt)};
                                end
                            end
                        end
                        default: begin
                            o_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ: begin
                if (r_rd_data[SW]) begin
                    n_cur = r_rd_data[SW-1:0];
                end else begin
                    n_blk = 1'b1;
                end
                n_state = ST_RUN;
            end
            default: begin
                n_state = ST_WIPE;
            end
        endcase
    end

    assign o_busy     = r_state == ST_WIPE;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_DATA_W - $bits(t_result)){1'b0}}, r_out_data};

    `DFA_ASSERT_IMPLY(a_no_pop_in_wipe, i_clk, i_rst_n, r_state == ST_WIPE,
        !o_pop && !mem_re, "queue popped or table read during clearing pass")
    `DFA_ASSERT_NEXT(a_wipe_full_sweep, i_clk, i_rst_n,
        r_state == ST_WIPE && r_wipe_addr != ADDRW'(DEPTH - 1),
        r_state == ST_WIPE, "clearing pass ended early")
    `DFA_ASSERT_NEXT(a_read_follows_issue, i_clk, i_rst_n, mem_re,
        r_state == ST_READ, "table read issued without waiting for data")
    `DFA_ASSERT_IMPLY(a_no_rw_collision, i_clk, i_rst_n, mem_we,
        !mem_re, "table written and read in the same cycle")
    `DFA_ASSERT_IMPLY(a_result_slot, i_clk, i_rst_n,
        r_out_valid && !i_m_tready && o_pop,
        i_head.action == ACT_FEED, "result produced while output register held")

endmodule

/* hdl/dfa_table_recognizer_top.sv */
// Top level of the table-driven DFA recognizer
//
// Channel   Dir  Handshake                   Payload
// s         in   i_s_tvalid / o_s_tready     i_s_tdata  (24 bits)
// m         out  o_m_tvalid / i_m_tready     o_m_tdata  (16 bits)
// cfg       in   i_cfg_wr_en                 i_cfg_wr_data (7 bits, state_count)
//
// Clear, mark, load, end-word and a feed on a blocked word are handled in the execution
// unit's ST_RUN state alone; a feed that reads the table also passes through ST_READ for the registered table read.
// Reset and each successful clear start a clearing pass over all MAX_STATES * 2**clog2(ALPHABET_SIZE)
// table entries (16384 by default) during which o_s_tready is low; config writes are still taken.
// A two-entry queue and the output register let input and output stall independently.
`timescale 1ns / 1ps
module dfa_table_recognizer_top
    import dfa_pkg::*;
#(
    parameter int MAX_STATES    = 64,
    parameter int ALPHABET_SIZE = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // action[2:0], state_index[8:3], symbol[16:9], target_state[23:17]
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // ok[0], accepted[1], blocked[2], stop_state[8:3], zero[15:9]
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    input  logic                  i_cfg_wr_en,
    input  logic [CNT_W-1:0]      i_cfg_wr_data
);

    logic             busy;
    logic             full;
    logic             empty;
    logic             push;
    logic             pop;
    t_cmd             cmd;
    t_cmd             head;
    logic [CNT_W-1:0] live;

    dfa_front #(
        .MAX_STATES    (MAX_STATES),
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_busy        (busy),
        .i_full        (full),
        .o_push        (push),
        .o_cmd         (cmd),
        .o_live        (live)
    );

    dfa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_head  (head)
    );

    dfa_back #(
        .MAX_STATES    (MAX_STATES),
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (empty),
        .i_head     (head),
        .o_pop      (pop),
        .i_live     (live),
        .o_busy     (busy),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

/* tb/dfa_table_recognizer_top_tb.sv */
// Self-checking testbench for the table-driven DFA recognizer top level
`timescale 1ns / 1ps
module dfa_table_recognizer_top_tb;
    import dfa_pkg::*;

    localparam int NUM_STATES    = 64;
    localparam int NUM_SYMS      = 256;
    localparam int SETTLE_CYCLES = 12;
    localparam int PHASE_ITEMS   = 110;
    localparam int NUM_PHASES    = 8;
    localparam logic [2:0] ACT_LAST_CODE = 3'd7;

    class dfa_scoreboard;
        int          next_tbl[NUM_STATES * NUM_SYMS];
        bit          accepting[NUM_STATES];
        int unsigned cur_state;
        bit          word_blocked;
        int unsigned state_count;
        t_result     expected_q[$];
        int          errors;
        int          noted;
        int          checked;
        int          words_accepted;
        int          words_blocked;

        function new();
            state_count = 0;
            wipe();
        endfunction

        function void wipe();
            foreach (next_tbl[k]) next_tbl[k] = -1;
            foreach (accepting[k]) accepting[k] = 1'b0;
            cur_state    = 0;
            word_blocked = 1'b0;
        endfunction

        function int unsigned live();
            return (state_count > NUM_STATES) ? NUM_STATES : state_count;
        endfunction

        function void note_input(logic [IN_DATA_W-1:0] word);
            t_result     res;
            logic [2:0]  act;
            int unsigned sidx;
            int unsigned sym;
            int          tgt;
            int unsigned n;
            int          nxt;
            bit          blk;
            act  = word[2:0];
            sidx = 32'(word[8:3]);
            sym  = 32'(word[16:9]);
            tgt  = 32'($signed(word[23:17]));
            n    = live();
            res  = '0;
            noted++;
            case (act)
                ACT_CLEAR: begin
                    if (state_count <= NUM_STATES) begin
                        wipe();
                        res.ok = 1'b1;
                    end
                    expected_q.push_back(res);
                end
                ACT_MARK: begin
                    if (sidx < n) begin
                        accepting[sidx] = 1'b1;
                        res.ok = 1'b1;
                    end
                    expected_q.push_back(res);
                end
                ACT_LOAD: begin
                    if (sidx < n && tgt >= -1 && tgt < int'(n)) begin
                        next_tbl[sidx * NUM_SYMS + sym] = tgt;
                        res.ok = 1'b1;
                    end
                    expected_q.push_back(res);
                end
                ACT_FEED: begin
                    if (!word_blocked) begin
                        if (cur_state >= n) begin
                            word_blocked = 1'b1;
                        end else begin
                            nxt = next_tbl[cur_state * NUM_SYMS + sym];
                            if (nxt < 0) word_blocked = 1'b1;
                            else cur_state = nxt;
                        end
                    end
                end
                ACT_END: begin
                    blk            = word_blocked || cur_state >= n;
                    res.ok         = 1'b1;
                    res.blocked    = blk;
                    res.stop_state = blk ? 6'd0 : cur_state[5:0];
                    res.accepted   = !blk && accepting[cur_state];
                    if (res.accepted) words_accepted++;
                    if (blk) words_blocked++;
                    expected_q.push_back(res);
                    cur_state    = 0;
                    word_blocked = 1'b0;
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] data);
            t_result exp_r;
            t_result got;
            got = t_result'(data[$bits(t_result)-1:0]);
            if (expected_q.size() == 0) begin
                $error("result %h arrived with nothing expected", data);
                errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            checked++;
            if (got.ok !== exp_r.ok) begin
                $error("ok: expected %0d, got %0d", exp_r.ok, got.ok);
                errors++;
            end
            if (got.accepted !== exp_r.accepted) begin
                $error("accepted: expected %0d, got %0d", exp_r.accepted, got.accepted);
                errors++;
            end
            if (got.blocked !== exp_r.blocked) begin
                $error("blocked: expected %0d, got %0d", exp_r.blocked, got.blocked);
                errors++;
            end
            if (got.stop_state !== exp_r.stop_state) begin
                $error("stop_state: expected %0d, got %0d", exp_r.stop_state, got.stop_state);
                errors++;
            end
            if (data[OUT_DATA_W-1:$bits(t_result)] !== '0) begin
                $error("pad: expected 0, got %h", data[OUT_DATA_W-1:$bits(t_result)]);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_s_tvalid    = 1'b0;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata     = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready    = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic                  i_cfg_wr_en   = 1'b0;
    logic [CNT_W-1:0]      i_cfg_wr_data = '0;

    int unsigned   src_idle_pct   = 12;
    int unsigned   sink_stall_pct = 69;
    int            settings_seen  = 0;
    dfa_scoreboard sb             = new();

    dfa_table_recognizer_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_result(o_m_tdata);
        i_m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    function automatic logic [IN_DATA_W-1:0] pack_item(logic [2:0] act, logic [5:0] sidx,
                                                       logic [7:0] sym, logic [6:0] tgt);
        return {tgt, sym, sidx, act};
    endfunction

    task automatic send(input logic [IN_DATA_W-1:0] word);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tdata  <= word;
        i_s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_input(word);
    endtask

    task automatic write_state_count(input logic [CNT_W-1:0] value);
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_wr_data <= value;
        i_cfg_wr_en   <= 1'b1;
        @(posedge i_clk);
        i_cfg_wr_en    <= 1'b0;
        sb.state_count = 32'(value);
        settings_seen++;
    endtask

    initial begin
        int unsigned counts[NUM_PHASES];
        logic [7:0]  alpha[4];
        logic [2:0]  act;
        int          n_eff;
        int          small_n;
        int          pick;
        int          sidx;
        int          sym;
        int          tgt;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero states: every word blocks and every set fails
        send(pack_item(ACT_END, 6'd0, 8'd0, 7'd0));
        send(pack_item(ACT_FEED, 6'd0, 8'hFF, 7'd0));
        send(pack_item(ACT_END, 6'd0, 8'd0, 7'd0));
        send(pack_item(ACT_MARK, 6'd0, 8'd0, 7'd0));
        send(pack_item(ACT_LOAD, 6'd0, 8'd0, 7'd0));

        write_state_count(7'd3);
        send(pack_item(ACT_CLEAR, 6'd0, 8'd0, 7'd0));
        send(pack_item(ACT_MARK, 6'd2, 8'd0, 7'd0));
        send(pack_item(ACT_MARK, 6'd3, 8'd0, 7'd0));
        send(pack_item(ACT_LOAD, 6'd0, 8'hFF, 7'd1));
        send(pack_item(ACT_LOAD, 6'd1, 8'h00, 7'd2));
        send(pack_item(ACT_LOAD, 6'd2, 8'h55, TGT_NONE));
        send(pack_item(ACT_LOAD, 6'd0, 8'h00, 7'h40));
        send(pack_item(ACT_LOAD, 6'd1, 8'h01, 7'd3));
        send(pack_item(ACT_LOAD, 6'd63, 8'h00, 7'd0));
        send(pack_item(ACT_FEED, 6'd0, 8'hFF, 7'd0));
        send(pack_item(ACT_FEED, 6'd0, 8'h00, 7'd0));
        send(pack_item(ACT_END, 6'd0, 8'd0, 7'd0));
        send(pack_item(ACT_FEED, 6'd0, 8'hFF, 7'd0));
        send(pack_item(ACT_FEED, 6'd0, 8'hAA, 7'd0));
        send(pack_item(ACT_FEED, 6'd0, 8'hFF, 7'd0));
        send(pack_item(ACT_END, 6'd0, 8'd0, 7'd0));

        // hold a word in state 2, then shrink the state count under it
        send(pack_item(ACT_FEED, 6'd0, 8'hFF, 7'd0));
        send(pack_item(ACT_FEED, 6'd0, 8'h00, 7'd0));
        write_state_count(7'd2);
        send(pack_item(ACT_END, 6'd0, 8'd0, 7'd0));
        send(pack_item(ACT_LAST_CODE, 6'd63, 8'hFF, 7'h7F));

        write_state_count(7'd127);
        send(pack_item(ACT_CLEAR, 6'd0, 8'd0, 7'd0));
        send(pack_item(ACT_MARK, 6'd63, 8'd0, 7'd0));

        counts = '{64, 1, 0, 127, 0, 64, 0, 0};
        counts[4] = $urandom_range(2, 63);
        counts[6] = $urandom_range(65, 126);
        counts[7] = $urandom_range(2, 20);
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph == 3) begin
                src_idle_pct   = 69;
                sink_stall_pct = 12;
            end
            if (ph == 6) begin
                src_idle_pct   = 0;
                sink_stall_pct = 0;
            end
            write_state_count(7'(counts[ph]));
            n_eff   = (counts[ph] > NUM_STATES) ? NUM_STATES : counts[ph];
            small_n = (n_eff > 8) ? 8 : n_eff;
            foreach (alpha[k]) alpha[k] = 8'($urandom_range(0, 255));
            send(pack_item(ACT_CLEAR, 6'($urandom), 8'($urandom), 7'($urandom)));
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                pick = $urandom_range(0, 99);
                sidx = $urandom_range(0, 63);
                if (n_eff > 0 && $urandom_range(0, 9) < 8)
                    sidx = $urandom_range(0, $urandom_range(0, 1) ? small_n - 1 : n_eff - 1);
                sym = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                  : alpha[$urandom_range(0, 3)];
                if ($urandom_range(0, 9) < 8)
                    tgt = int'($urandom_range(0, $urandom_range(0, 1) ? small_n : n_eff)) - 1;
                else
                    tgt = $urandom_range(0, 127);
                if (pick < 40) act = ACT_FEED;
                else if (pick < 65) act = ACT_LOAD;
                else if (pick < 75) act = ACT_MARK;
                else if (pick < 93) act = ACT_END;
                else if (pick < 97) act = 3'($urandom_range(ACT_END + 1, ACT_LAST_CODE));
                else act = (counts[ph] > NUM_STATES) ? ACT_CLEAR : ACT_END;
                send(pack_item(act, 6'(sidx), 8'(sym), 7'(tgt)));
            end
        end

        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Sent %0d transfers under %0d state_count settings, checked %0d results",
                 sb.noted, settings_seen, sb.checked);
        $display("Words ended: %0d accepted, %0d blocked", sb.words_accepted, sb.words_blocked);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

/* dfa_table_recognizer_top.f */
+incdir+hdl
hdl/dfa_pkg.sv
hdl/dfa_front.sv
hdl/dfa_queue.sv
hdl/dfa_back.sv
hdl/dfa_table_recognizer_top.sv
tb/dfa_table_recognizer_top_tb.sv
